/* design/zwpt_pkg.sv */
package zwpt_pkg;

  // Storage sizing.
  localparam int MAX_BANDS    = 1024;
  localparam int POINTER_BITS = 21;
  localparam int PTR_W        = POINTER_BITS;
  localparam int BAND_AW      = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int BAND_CW      = $clog2(MAX_BANDS + 1);

  // Fixed field widths.
  localparam int OP_W         = 3;
  localparam int BAND_W       = 10;
  localparam int SECT_W       = 21;
  localparam int NB_W         = 11;
  localparam int ST_W         = 3;
  localparam int ADDR_W       = 30;
  localparam int OUT_PTR_W    = 21;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 21;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd1;
  localparam logic [OP_W-1:0] OP_RST_BAND = 3'd2;
  localparam logic [OP_W-1:0] OP_RST_ALL  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_BAND = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [ST_W-1:0] ST_OFF_PTR  = 3'd3;
  localparam logic [ST_W-1:0] ST_PAST_PTR = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BANDS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_LEN  = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BAND_W-1:0] band;
    logic [SECT_W-1:0] offset;
    logic [SECT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [ADDR_W-1:0]    sector_address;
    logic [OUT_PTR_W-1:0] write_pointer;
    logic                 ptr_we;
    logic [PTR_W-1:0]     ptr_wdata;
    logic                 vld_we;
    logic                 vld_wdata;
    logic                 rst_all;
  } chk_t;

endpackage

/* design/zwpt_ram.sv */
module zwpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/zwpt_check.sv */
module zwpt_check (
  input  zwpt_pkg::cmd_t                   cmd,
  input  logic [zwpt_pkg::NB_W-1:0]        num_bands,
  input  logic [zwpt_pkg::SECT_W-1:0]      zone_len,
  input  logic [zwpt_pkg::ADDR_W-1:0]      prod,
  input  logic                             vld_rd,
  input  logic [zwpt_pkg::PTR_W-1:0]       ptr_rd,
  output zwpt_pkg::chk_t                   chk
);
  import zwpt_pkg::*;

  logic [PTR_W-1:0]        ptr_cur;
  logic [PTR_W-1:0]        ptr_o;
  logic [SECT_W:0]         sum_oc;
  logic [32:0]             sum33;
  logic [32:0]             ptr33;
  logic [32:0]             off33;
  logic [32:0]             nxt33;
  logic [PTR_W+OUT_PTR_W-1:0] ptr_ext;
  logic                    bad;

  always_comb begin
    ptr_cur = vld_rd ? ptr_rd : '0;
    sum_oc  = {1'b0, cmd.offset} + {1'b0, cmd.count};
    sum33   = 33'(sum_oc);
    ptr33   = 33'(ptr_cur);
    off33   = 33'(cmd.offset);
    nxt33   = ptr33 + 33'(cmd.count);
    bad     = ({1'b0, cmd.band} >= num_bands) ||
              (32'(cmd.band) >= 32'(MAX_BANDS));

    ptr_o              = ptr_cur;
    chk.status         = ST_OK;
    chk.sector_address = prod + ADDR_W'(cmd.offset);
    chk.ptr_we         = 1'b0;
    chk.ptr_wdata      = nxt33[PTR_W-1:0];
    chk.vld_we         = 1'b0;
    chk.vld_wdata      = 1'b0;
    chk.rst_all        = 1'b0;

    if (cmd.opcode == OP_RST_ALL) begin
      chk.sector_address = '0;
      ptr_o              = '0;
      chk.rst_all        = 1'b1;
    end else if (bad) begin
      chk.status = ST_BAD_BAND;
      ptr_o      = '0;
    end else begin
      case (cmd.opcode)
        OP_READ: begin
          if (cmd.offset >= zone_len) begin
            chk.status = ST_RANGE;
          end else if (sum33 > ptr33) begin
            chk.status = ST_PAST_PTR;
          end
        end
        OP_WRITE: begin
          if (sum_oc > {1'b0, zone_len}) begin
            chk.status = ST_RANGE;
          end else if (off33 != ptr33) begin
            chk.status = ST_OFF_PTR;
          end else begin
            ptr_o         = nxt33[PTR_W-1:0];
            chk.ptr_we    = 1'b1;
            chk.vld_we    = 1'b1;
            chk.vld_wdata = 1'b1;
          end
        end
        OP_RST_BAND: begin
          chk.vld_we = 1'b1;
          ptr_o      = '0;
        end
        default: begin
          // Query and the unused opcodes report the current pointer.
        end
      endcase
    end

    ptr_ext           = {{OUT_PTR_W{1'b0}}, ptr_o};
    chk.write_pointer = ptr_ext[OUT_PTR_W-1:0];
  end

endmodule

/* design/zone_write_pointer_tracker_core.sv */
// Zone write pointer tracker. The block keeps one write pointer per band of a
// shingled disk and checks each command against it: reads must start inside
// the band and end at or below the pointer, writes must start exactly at the
// pointer and fit in the band, and an accepted write advances the pointer.
// Every command transaction returns exactly one result transaction carrying
// a status, the linear sector address band times the band length plus offset
// (wrapped to 30 bits) and the band's pointer after the command. Pointers live
// in one single-port-style RAM and per-band valid bits in a second one; both
// have a registered read. A command is accepted in the idle state; the memory
// read and the band times band length multiply run in the read state; the
// check, write back and result register load run in the check state, which
// waits while the previous result is still held. Only one command is in
// flight, so each write-back lands before the next read and no forwarding
// is needed. The next command is accepted while the previous result still
// waits in the output register. After reset the block runs a clearing pass
// over all MAX_BANDS (1024) valid bits before the first command is taken; a
// reset-all command clears the valid bits of bands 0 .. min(num_bands,
// MAX_BANDS)-1 with the same sweep, holding off new commands until the
// sweep ends. Configuration writes are taken at any time but must only be
// issued while the block is idle.
module zone_write_pointer_tracker_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [zwpt_pkg::OP_W-1:0]            in_opcode,
  input  logic [zwpt_pkg::BAND_W-1:0]          in_band,
  input  logic [zwpt_pkg::SECT_W-1:0]          in_offset,
  input  logic [zwpt_pkg::SECT_W-1:0]          in_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [zwpt_pkg::ST_W-1:0]            out_status,
  output logic [zwpt_pkg::ADDR_W-1:0]          out_sector_address,
  output logic [zwpt_pkg::OUT_PTR_W-1:0]       out_write_pointer,
  input  logic                                 cfg_we,
  input  logic [zwpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [zwpt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import zwpt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [BAND_CW-1:0]  swp_cnt_r, swp_cnt_nxt;
  logic [BAND_CW-1:0]  swp_lim_r, swp_lim_nxt;
  logic [NB_W-1:0]     num_bands_r;
  logic [SECT_W-1:0]   zone_len_r;
  cmd_t                cmd_r;
  logic [ADDR_W-1:0]   prod_r;
  logic                out_valid_r;
  logic [ST_W-1:0]     out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [OUT_PTR_W-1:0] out_ptr_r;

  logic                accept;
  logic                advance;
  logic [30:0]         prod_full;
  logic [BAND_AW+BAND_W-1:0] band_ext;
  logic [BAND_AW-1:0]  band_idx;
  logic [31:0]         lim32;
  logic [BAND_CW-1:0]  rst_lim;
  logic                sweeping;
  logic                ptr_we;
  logic                vld_we;
  logic                vld_wdata;
  logic [BAND_AW-1:0]  vld_waddr;
  logic                mem_re;
  logic [PTR_W-1:0]    ptr_rd;
  logic                vld_rd;
  chk_t                chk;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign advance   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign sweeping  = (state_r == S_SWEEP);
  assign mem_re    = (state_r == S_READ);
  assign band_ext  = {{BAND_AW{1'b0}}, cmd_r.band};
  assign band_idx  = band_ext[BAND_AW-1:0];
  assign prod_full = 31'(cmd_r.band) * 31'(zone_len_r);
  assign lim32     = (32'(num_bands_r) < 32'(MAX_BANDS)) ? 32'(num_bands_r)
                                                        : 32'(MAX_BANDS);
  assign rst_lim   = lim32[BAND_CW-1:0];

  assign ptr_we    = advance && chk.ptr_we;
  assign vld_we    = sweeping || (advance && chk.vld_we);
  assign vld_wdata = sweeping ? 1'b0 : chk.vld_wdata;
  assign vld_waddr = sweeping ? swp_cnt_r[BAND_AW-1:0] : band_idx;

  zwpt_ram #(.WIDTH(PTR_W), .DEPTH(MAX_BANDS)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (band_idx),
    .wdata (chk.ptr_wdata),
    .re    (mem_re),
    .raddr (band_idx),
    .rdata (ptr_rd)
  );

  zwpt_ram #(.WIDTH(1), .DEPTH(MAX_BANDS)) u_vld_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .re    (mem_re),
    .raddr (band_idx),
    .rdata (vld_rd)
  );

  zwpt_check u_check (
    .cmd       (cmd_r),
    .num_bands (num_bands_r),
    .zone_len  (zone_len_r),
    .prod      (prod_r),
    .vld_rd    (vld_rd),
    .ptr_rd    (ptr_rd),
    .chk       (chk)
  );

  // Sequencer: idle, memory read, check and write back, valid-bit sweep.
  always_comb begin
    state_nxt   = state_r;
    swp_cnt_nxt = swp_cnt_r;
    swp_lim_nxt = swp_lim_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (advance) begin
          if (chk.rst_all && (rst_lim != '0)) begin
            state_nxt   = S_SWEEP;
            swp_cnt_nxt = '0;
            swp_lim_nxt = rst_lim;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SWEEP: begin
        swp_cnt_nxt = swp_cnt_r + BAND_CW'(1);
        if (swp_cnt_nxt == swp_lim_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Reset starts a full clearing pass over the valid bits.
      state_r     <= S_SWEEP;
      swp_cnt_r   <= '0;
      swp_lim_r   <= BAND_CW'(MAX_BANDS);
      out_valid_r <= 1'b0;
      num_bands_r <= NB_W'(1024);
      zone_len_r  <= SECT_W'(65536);
    end else begin
      state_r   <= state_nxt;
      swp_cnt_r <= swp_cnt_nxt;
      swp_lim_r <= swp_lim_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_BANDS: num_bands_r <= cfg_wdata[NB_W-1:0];
          CFG_ZONE_LEN:  zone_len_r  <= cfg_wdata[SECT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.opcode <= in_opcode;
      cmd_r.band   <= in_band;
      cmd_r.offset <= in_offset;
      cmd_r.count  <= in_count;
    end
    if (state_r == S_READ) begin
      prod_r <= prod_full[ADDR_W-1:0];
    end
    if (advance) begin
      out_status_r <= chk.status;
      out_addr_r   <= chk.sector_address;
      out_ptr_r    <= chk.write_pointer;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_sector_address = out_addr_r;
  assign out_write_pointer  = out_ptr_r;

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_READ))
    else $error("accepted transaction did not start a memory read");

  a_ptr_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_we |-> (state_r == S_EXEC))
    else $error("pointer memory written outside the check cycle");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> (swp_cnt_r < swp_lim_r))
    else $error("valid sweep ran past its limit");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && out_valid_r && !out_ready) |=> (state_r == S_EXEC))
    else $error("result overwritten while the previous one waits");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

// Top-level testbench for the zone write pointer tracker.
module tb;
  import zwpt_pkg::*;

  // One expected or observed result transaction.
  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [ADDR_W-1:0]    sector_address;
    logic [OUT_PTR_W-1:0] write_pointer;
  } zone_result_t;

  // Shadow of the tracker. It keeps its own copy of the per-band pointers,
  // the valid bits and both registers. Each accepted command transaction is
  // turned into the result it must produce, and results are checked in order.
  class zone_ptr_board;
    logic [PTR_W-1:0] ptr_mem [MAX_BANDS];
    bit               band_live [MAX_BANDS];
    int unsigned      num_bands_r;
    int unsigned      zone_len_r;
    zone_result_t     pending_results [$];
    int unsigned      commands;
    int unsigned      results;
    int unsigned      mismatches;
    int unsigned      status_seen [8];

    function new();
      // Register reset values: 1024 bands of 65536 sectors.
      num_bands_r = 1024;
      zone_len_r = 65536;
      foreach (band_live[i]) begin
        band_live[i] = 1'b0;
        ptr_mem[i] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
      commands = 0;
      results = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_NUM_BANDS) begin
        num_bands_r = int'(val[NB_W-1:0]);
      end else if (idx == CFG_ZONE_LEN) begin
        zone_len_r = int'(val[SECT_W-1:0]);
      end
    endfunction

    // Bands beyond the storage are never addressable, whatever the register says.
    function int unsigned live_bands();
      return (num_bands_r < MAX_BANDS) ? num_bands_r : MAX_BANDS;
    endfunction

    // A band whose valid bit is clear reads as an empty band.
    function int unsigned pointer_of(int unsigned b);
      return band_live[b] ? int'(ptr_mem[b]) : 0;
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [BAND_W-1:0] band,
                               logic [SECT_W-1:0] off, logic [SECT_W-1:0] cnt);
      zone_result_t r;
      bit [63:0]    lin;
      int unsigned  live;
      int unsigned  p;
      int unsigned  i;
      live = live_bands();
      lin = 64'(band) * 64'(zone_len_r) + 64'(off);
      r.status = ST_OK;
      r.sector_address = lin[ADDR_W-1:0];
      r.write_pointer = '0;
      p = 0;
      if (op == OP_RST_ALL) begin
        // Only the bands in use lose their valid bit.
        for (i = 0; i < live; i++) band_live[i] = 1'b0;
        r.sector_address = '0;
      end else if (int'(band) >= live) begin
        r.status = ST_BAD_BAND;
      end else begin
        p = pointer_of(int'(band));
        case (op)
          OP_READ: begin
            // Only the start is checked against the band size on a read.
            if (int'(off) >= zone_len_r) r.status = ST_RANGE;
            else if (64'(off) + 64'(cnt) > 64'(p)) r.status = ST_PAST_PTR;
          end
          OP_WRITE: begin
            if (64'(off) + 64'(cnt) > 64'(zone_len_r)) begin
              r.status = ST_RANGE;
            end else if (int'(off) != p) begin
              r.status = ST_OFF_PTR;
            end else begin
              ptr_mem[band] = PTR_W'(p + int'(cnt));
              band_live[band] = 1'b1;
              p = int'(ptr_mem[band]);
            end
          end
          OP_RST_BAND: begin
            band_live[band] = 1'b0;
            p = 0;
          end
          // Queries and the unused opcodes just report the pointer.
          default: ;
        endcase
        r.write_pointer = OUT_PTR_W'(p);
      end
      pending_results.push_back(r);
      commands++;
    endfunction

    function void check_result(logic [ST_W-1:0] st, logic [ADDR_W-1:0] addr,
                               logic [OUT_PTR_W-1:0] wp);
      zone_result_t want;
      results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d address %0d pointer %0d",
                 $time, st, addr, wp);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      status_seen[want.status]++;
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        mismatches++;
      end
      if (addr !== want.sector_address) begin
        $display("%0t: sector address expected %0d actual %0d",
                 $time, want.sector_address, addr);
        mismatches++;
      end
      if (wp !== want.write_pointer) begin
        $display("%0t: write pointer expected %0d actual %0d",
                 $time, want.write_pointer, wp);
        mismatches++;
      end
    endfunction
  endclass

  localparam int unsigned SECT_MAX = (1 << SECT_W) - 1;
  localparam int unsigned ZONE_SETTINGS = 12;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_opcode = '0;
  logic [BAND_W-1:0]     in_band = '0;
  logic [SECT_W-1:0]     in_offset = '0;
  logic [SECT_W-1:0]     in_count = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ST_W-1:0]       out_status;
  logic [ADDR_W-1:0]     out_sector_address;
  logic [OUT_PTR_W-1:0]  out_write_pointer;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  zone_ptr_board board;
  int unsigned   zone_counts [ZONE_SETTINGS];
  int unsigned   zone_sizes [ZONE_SETTINGS];

  // Receiver stall pattern state.
  int unsigned   rx_mode = 0;
  logic [7:0]    rx_left = '0;

  zone_write_pointer_tracker_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_band            (in_band),
    .in_offset          (in_offset),
    .in_count           (in_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_sector_address (out_sector_address),
    .out_write_pointer  (out_write_pointer),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver switches at random between several stall styles: always
  // ready, coin flip, mostly stalled, and a square wave. This way stalls land
  // on every phase of the idle, read and check command sequence.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= 8'($urandom_range(20, 120));
    end else begin
      rx_left <= rx_left - 8'd1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= rx_left[3];
    endcase
  end

  // Result monitor. Values are sampled at the edge before any register in the
  // block updates, so the transaction seen here is the one that completes.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_status, out_sector_address, out_write_pointer);
    end
  end

  // Presents one command transaction and holds it until the block takes it.
  // The caller is always just past a rising edge, so valid and the payload
  // change only there. Valid is left high; the next call or an idle stretch
  // decides what happens to it.
  task automatic push_command(logic [OP_W-1:0] op, logic [BAND_W-1:0] band,
                              logic [SECT_W-1:0] off, logic [SECT_W-1:0] cnt);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_band <= band;
    in_offset <= off;
    in_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_command(op, band, off, cnt);
  endtask

  task automatic rest_sender(int unsigned n);
    if (n == 0) return;
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // After the last result a reset-all sweep may still be clearing valid bits,
  // so registers are only touched once it has had time to end.
  task automatic settle_zones();
    wait_results();
    repeat (MAX_BANDS + 8) @(posedge clk);
  endtask

  task automatic program_zones(int unsigned nb, int unsigned bs);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NUM_BANDS;
    cfg_wdata <= CFG_DATA_W'(nb);
    @(posedge clk);
    board.set_reg(CFG_NUM_BANDS, CFG_DATA_W'(nb));
    cfg_index <= CFG_ZONE_LEN;
    cfg_wdata <= CFG_DATA_W'(bs);
    @(posedge clk);
    board.set_reg(CFG_ZONE_LEN, CFG_DATA_W'(bs));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Most traffic goes to a few low bands so they fill up and get reset; some
  // goes to the top bands, which turn into bad bands when few are in use.
  function automatic int unsigned pick_band();
    int unsigned live;
    int unsigned hot;
    live = board.live_bands();
    if (live == 0) return $urandom_range(0, MAX_BANDS - 1);
    hot = (live < 8) ? live : 8;
    case ($urandom_range(0, 3))
      0, 1: return $urandom_range(0, hot - 1);
      2: return $urandom_range(MAX_BANDS - 8, MAX_BANDS - 1);
      default: return $urandom_range(0, live - 1);
    endcase
  endfunction

  // Directed cases under the reset register values: empty band, zero counts,
  // each status but bad band, a band filled exactly to its end, the top band
  // with the largest offsets and counts, the unused opcodes, and both resets.
  task automatic run_directed();
    int unsigned u;
    push_command(OP_QUERY, 10'd0, 21'd0, 21'd0);
    push_command(OP_READ, 10'd0, 21'd0, 21'd0);
    push_command(OP_READ, 10'd0, 21'd0, 21'd1);
    push_command(OP_WRITE, 10'd0, 21'd1, 21'd1);
    push_command(OP_WRITE, 10'd0, 21'd0, 21'd65537);
    push_command(OP_WRITE, 10'd0, 21'd0, 21'd0);
    push_command(OP_WRITE, 10'd0, 21'd0, 21'd65536);
    push_command(OP_READ, 10'd0, 21'd65535, 21'd1);
    push_command(OP_READ, 10'd0, 21'd65536, 21'd0);
    push_command(OP_WRITE, 10'd0, 21'd65536, 21'd0);
    push_command(OP_WRITE, 10'd1023, 21'd0, 21'd100);
    push_command(OP_READ, 10'd1023, 21'd0, 21'd100);
    push_command(OP_READ, 10'd1023, 21'd50, 21'd51);
    push_command(OP_QUERY, 10'd1023, '1, '1);
    // Opcodes above the query code behave as queries.
    for (u = int'(OP_QUERY) + 1; u <= int'({OP_W{1'b1}}); u++) begin
      push_command(OP_W'(u), 10'd1023, '1, '1);
    end
    push_command(OP_READ, 10'd1023, '1, '1);
    push_command(OP_WRITE, 10'd1023, '1, '1);
    push_command(OP_RST_BAND, 10'd1023, 21'd0, 21'd0);
    push_command(OP_QUERY, 10'd1023, 21'd0, 21'd0);
    push_command(OP_RST_ALL, '1, '1, '1);
    push_command(OP_QUERY, 10'd0, 21'd0, 21'd0);
  endtask

  // Random traffic for one register setting. Most commands are well formed
  // (writes at the pointer, reads under it) so bands fill and pointers climb;
  // the rest are near misses and fully random transactions.
  task automatic run_random(int unsigned n, bit steady);
    int unsigned     k;
    int unsigned     burst;
    int unsigned     kind;
    int unsigned     b;
    int unsigned     p;
    int unsigned     bs;
    int unsigned     room;
    int unsigned     cap;
    int unsigned     o;
    int unsigned     c;
    logic [OP_W-1:0] op;
    burst = 0;
    bs = board.zone_len_r;
    for (k = 0; k < n; k++) begin
      if (!steady && burst == 0) begin
        rest_sender($urandom_range(1, 12));
        burst = $urandom_range(1, 40);
      end
      if (burst > 0) burst--;
      kind = $urandom_range(0, 99);
      b = (kind >= 85) ? $urandom_range(0, MAX_BANDS - 1) : pick_band();
      p = board.pointer_of(b);
      room = (bs > p) ? bs - p : 0;
      op = OP_QUERY;
      o = $urandom_range(0, SECT_MAX);
      c = $urandom_range(0, SECT_MAX);
      if (kind < 35) begin
        op = OP_WRITE;
        o = p;
        cap = room;
        if ($urandom_range(0, 3) != 0 && cap > bs / 6 + 1) cap = bs / 6 + 1;
        c = ($urandom_range(0, 3) == 0) ? room : $urandom_range(0, cap);
      end else if (kind < 60) begin
        op = OP_READ;
        o = (p > 0) ? $urandom_range(0, p - 1) : 0;
        c = p - o;
        if ($urandom_range(0, 3) == 0) c = c + $urandom_range(1, 3);
        else c = $urandom_range(0, c);
      end else if (kind < 68) begin
        op = OP_W'($urandom_range(int'(OP_QUERY), int'({OP_W{1'b1}})));
      end else if (kind < 73) begin
        op = OP_RST_BAND;
      end else if (kind < 74) begin
        op = OP_RST_ALL;
      end else if (kind < 85) begin
        op = OP_WRITE;
        case ($urandom_range(0, 2))
          0: begin
            o = p + 1;
            c = $urandom_range(0, 4);
          end
          1: begin
            o = (p > 0) ? p - 1 : p + 2;
            c = $urandom_range(0, 4);
          end
          default: begin
            o = p;
            c = room + 1;
          end
        endcase
      end else begin
        op = OP_W'($urandom_range(0, int'({OP_W{1'b1}})));
      end
      push_command(op, BAND_W'(b), SECT_W'(o), SECT_W'(c));
    end
  endtask

  initial begin
    int unsigned ph;
    board = new();
    zone_counts = '{1024, 1, 1024, 0, 2047, 5, 8, 1025, 0, 0, 1023, 0};
    zone_sizes = '{65536, 1, 2097151, 100, 16, 0, 3, 1048576, 0, 0, 7, 0};
    // A few settings are drawn at random: small bands that fill quickly,
    // a handful of mid-sized bands, and anything the register widths allow.
    zone_counts[8] = $urandom_range(1, 1024);
    zone_sizes[8] = $urandom_range(1, 64);
    zone_counts[9] = $urandom_range(1, 16);
    zone_sizes[9] = $urandom_range(1, 2000);
    zone_counts[11] = $urandom_range(0, 2047);
    zone_sizes[11] = $urandom_range(0, SECT_MAX);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The block runs its clearing pass first; push_command just waits on ready.
    run_directed();
    settle_zones();

    for (ph = 0; ph < ZONE_SETTINGS; ph++) begin
      program_zones(zone_counts[ph], zone_sizes[ph]);
      run_random(150, ph % 3 == 1);
      settle_zones();
    end

    wait_results();
    repeat (16) @(posedge clk);
    $display("Run covered %0d command transactions over %0d register settings, %0d results.",
             board.commands, ZONE_SETTINGS, board.results);
    $display("Status mix: ok %0d, bad band %0d, outside band %0d, off pointer %0d, past %0d.",
             board.status_seen[ST_OK], board.status_seen[ST_BAD_BAND],
             board.status_seen[ST_RANGE], board.status_seen[ST_OFF_PTR],
             board.status_seen[ST_PAST_PTR]);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(64'd10_000_000);
    $display("Timeout with %0d results still outstanding.", board.pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
